// ===== rtl/core/csc_pkg.sv =====
`timescale 1ns / 1ps
package csc_pkg;

  localparam int MAX_YEAR   = 3000;
  localparam int PIPE_DEPTH = 6;

  localparam logic [63:0] LIM_FULL =
      (64'd365 * 64'(MAX_YEAR + 1) + 64'(MAX_YEAR / 4)) * 64'd86400 - 64'd1;
  localparam logic [63:0] MASK37 = 64'h1F_FFFF_FFFF;
  localparam logic [36:0] SEC_LIMIT = (LIM_FULL > MASK37) ? MASK37[36:0] : LIM_FULL[36:0];

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  localparam logic [30:0] RECIP_DAY  = 31'(((64'd1 << 40) + 64'd674) / 64'd675);
  localparam logic [21:0] RECIP_YEAR = 22'(((64'd1 << 30) + 64'd364) / 64'd365);
  localparam logic [13:0] RECIP_HOUR = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
  localparam logic [10:0] RECIP_MIN  = 11'(((64'd1 << 14) + 64'd14) / 64'd15);

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  function automatic logic is_leap(input logic [12:0] y);
    return (y[1:0] == 2'd0) && (y != 13'd0);
  endfunction

  function automatic logic [21:0] year_start(input logic [12:0] y);
    logic [12:0] ym1;
    ym1 = y - 13'd1;
    if (y == 13'd0) return 22'd0;
    return 22'(y) * 22'd365 + 22'(ym1 >> 2);
  endfunction

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && idx >= 4'd2 && idx <= 4'd11) v = v + 9'd1;
    return v;
  endfunction

endpackage

// ===== rtl/core/calendar_seconds_converter_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tdata: date fields and seconds, tuser: func
// m_*      out  tvalid/tready    tdata: seconds and date fields, tuser: error
//
// One transaction enters per cycle when the output side keeps up.
// The six-stage pipeline advances as a whole; it holds while the last stage
// has a result that the sink does not take.
// Reset clears the stage valid bits only.
module calendar_seconds_converter_unit import csc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // hour_in[4:0] minute_in[10:5] second_in[16:11] day_in[21:17] month_in[25:22]
  // year_in[37:26] seconds_in[74:38], zero fill to 80
  input  logic [79:0] s_tdata,
  // func[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // seconds_out[36:0] hour_out[41:37] minute_out[47:42] second_out[53:48]
  // day_out[58:54] month_out[62:59] year_out[74:63], zero fill to 80
  output logic [79:0] m_tdata,
  // error[0]
  output logic        m_tuser
);

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] fn;
  logic [36:0]           secs;
  logic                  err;
  date_t                 date;
  logic                  to_date;

  assign en       = !vld[PIPE_DEPTH-1] || m_tready;
  assign s_tready = en;

  csc_to_seconds u_sec (
    .clk        (clk),
    .en         (en),
    .hour_in    (s_tdata[4:0]),
    .minute_in  (s_tdata[10:5]),
    .second_in  (s_tdata[16:11]),
    .day_in     (s_tdata[21:17]),
    .month_in   (s_tdata[25:22]),
    .year_in    (s_tdata[37:26]),
    .seconds_out(secs),
    .error      (err)
  );

  csc_to_date u_date (
    .clk       (clk),
    .en        (en),
    .seconds_in(s_tdata[74:38]),
    .date      (date)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn <= {fn[PIPE_DEPTH-2:0], s_tuser};
    end
  end

  assign to_date  = fn[PIPE_DEPTH-1];
  assign m_tvalid = vld[PIPE_DEPTH-1];
  assign m_tuser  = !to_date && err;
  assign m_tdata  = to_date
      ? {5'd0, date.year, date.month, date.day, date.second, date.minute, date.hour, 37'd0}
      : {43'd0, secs};

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[36:0] == 37'd0)
    else $error("error result carries nonzero seconds");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[41:37] < 5'd24 && m_tdata[47:42] < 6'd60 && m_tdata[53:48] < 6'd60)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && to_date |-> m_tdata[58:54] != 5'd0 && m_tdata[62:59] != 4'd0
                            && m_tdata[62:59] <= 4'd12)
    else $error("date fields out of range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

endmodule

// ===== rtl/core/csc_to_seconds.sv =====
`timescale 1ns / 1ps
module csc_to_seconds import csc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  input  logic [4:0]  day_in,
  input  logic [3:0]  month_in,
  input  logic [11:0] year_in,
  output logic [36:0] seconds_out,
  output logic        error
);

  logic [3:0]  mon_c;
  logic [3:0]  mon_idx;
  logic [12:0] y13;
  logic [21:0] d_next;
  logic [16:0] tod_next;
  logic [21:0] d1;
  logic [16:0] tod1;
  logic        err1;
  logic [38:0] tot2;
  logic        err2;
  logic [38:0] t_sub;
  logic [36:0] sec_next;
  logic [36:0] sec_d [4];
  logic        err_d [4];

  always_comb begin
    mon_c    = (month_in > 4'd12) ? 4'd12 : month_in;
    mon_idx  = mon_c - 4'd1;
    y13      = {1'b0, year_in};
    d_next   = year_start(y13) + 22'(month_start(is_leap(y13), mon_idx)) + 22'(day_in);
    tod_next = 17'(hour_in) * 17'(SECS_PER_HOUR) + 17'(minute_in) * 17'(SECS_PER_MIN)
             + 17'(second_in);
  end

  always_comb begin
    t_sub = tot2 - 39'(SECS_PER_DAY);
    if (err2 || tot2 < 39'(SECS_PER_DAY)) begin
      sec_next = '0;
    end else if (t_sub > 39'(SEC_LIMIT)) begin
      sec_next = SEC_LIMIT;
    end else begin
      sec_next = t_sub[36:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1       <= d_next;
      tod1     <= tod_next;
      err1     <= (month_in == 4'd0);
      tot2     <= 39'(d1) * 39'(SECS_PER_DAY) + 39'(tod1);
      err2     <= err1;
      sec_d[0] <= sec_next;
      err_d[0] <= err2;
      for (int i = 1; i < 4; i++) begin
        sec_d[i] <= sec_d[i-1];
        err_d[i] <= err_d[i-1];
      end
    end
  end

  assign seconds_out = sec_d[3];
  assign error       = err_d[3];

endmodule

// ===== rtl/core/csc_to_date.sv =====
`timescale 1ns / 1ps
module csc_to_date import csc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [36:0] seconds_in,
  output date_t       date
);

  logic [36:0] sc;
  logic [36:0] s1;
  logic [60:0] p1;
  logic [20:0] days2;
  logic [16:0] rem2;
  logic [20:0] days3;
  logic [16:0] rem3;
  logic [12:0] y3;
  logic [4:0]  hour3;
  logic [12:0] y4;
  logic [8:0]  doy4;
  logic [4:0]  hour4;
  logic [11:0] msr4;
  logic [12:0] y5;
  logic [3:0]  mon5;
  logic [4:0]  day5;
  logic [4:0]  hour5;
  logic [5:0]  min5;
  logic [11:0] msr5;
  logic [11:0] y6;
  logic [3:0]  mon6;
  logic [4:0]  day6;
  logic [12:0] y_sel;
  logic [21:0] ys_sel;
  logic [12:0] y_cand [4];
  logic [21:0] ys_cand [4];
  logic [3:0]  m_idx;
  logic [8:0]  ms_sel;
  logic        leap4;

  assign sc    = (seconds_in > SEC_LIMIT) ? SEC_LIMIT : seconds_in;
  assign days2 = p1[60:40];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      y_cand[k]  = y3 - 13'(k);
      ys_cand[k] = year_start(y_cand[k]);
    end
    y_sel  = y_cand[3];
    ys_sel = ys_cand[3];
    for (int k = 2; k >= 0; k--) begin
      if (y3 >= 13'(k) && ys_cand[k] <= 22'(days3)) begin
        y_sel  = y_cand[k];
        ys_sel = ys_cand[k];
      end
    end
  end

  always_comb begin
    leap4 = is_leap(y4);
    m_idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy4 >= month_start(leap4, 4'(m))) m_idx = 4'(m);
    end
    ms_sel = month_start(leap4, m_idx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= sc;
      p1    <= 61'(sc[36:7]) * 61'(RECIP_DAY);
      rem2  <= 17'(s1 - 37'(days2) * 37'(SECS_PER_DAY));
      days3 <= days2;
      rem3  <= rem2;
      y3    <= 13'((43'(days2) * 43'(RECIP_YEAR)) >> 30);
      hour3 <= 5'((27'(rem2[16:4]) * 27'(RECIP_HOUR)) >> 21);
      y4    <= y_sel;
      doy4  <= 9'(22'(days3) - ys_sel);
      hour4 <= hour3;
      msr4  <= 12'(rem3 - 17'(hour3) * 17'(SECS_PER_HOUR));
      y5    <= y4;
      mon5  <= m_idx + 4'd1;
      day5  <= 5'(doy4 - ms_sel + 9'd1);
      hour5 <= hour4;
      min5  <= 6'((21'(msr4[11:2]) * 21'(RECIP_MIN)) >> 14);
      msr5  <= msr4;
      y6    <= y5[11:0];
      mon6  <= mon5;
      day6  <= day5;
      date.year   <= y6;
      date.month  <= mon6;
      date.day    <= day6;
      date.hour   <= hour5;
      date.minute <= min5;
      date.second <= 6'(msr5 - 12'(min5) * 12'(SECS_PER_MIN));
    end
  end

endmodule
